// ===== sv/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// shared types and defaults for the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DEF_ID_BITS     = 8;

    // action carried with each input transfer
    typedef enum logic [1:0] {
        ACT_ADD_ABS = 2'd0,
        ACT_ADD_REL = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    // kind of each result transfer
    typedef enum logic [1:0] {
        KIND_FIRED  = 2'd0,
        KIND_HEAD   = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_APPLY  = 2'd1,
        ST_FIRE   = 2'd2,
        ST_REPORT = 2'd3
    } state_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctl_t;

endpackage

// ===== sv/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// one queue slot: holds an (id, expiry) pair and shifts with its neighbours
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_BITS = stq_pkg::DEF_TIME_BITS,
    parameter int ID_BITS   = stq_pkg::DEF_ID_BITS
) (
    input  logic                 aclk,
    input  stq_pkg::cell_ctl_t   ctl,
    input  logic [TIME_BITS-1:0] key_exp,
    input  logic [ID_BITS-1:0]   key_id,
    input  logic [TIME_BITS-1:0] left_exp,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic                 left_gt,
    input  logic [TIME_BITS-1:0] right_exp,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic                 match_in,
    output logic [TIME_BITS-1:0] exp_q,
    output logic [ID_BITS-1:0]   id_q,
    output logic                 gt,
    output logic                 match_out
);
    import stq_pkg::*;

    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic                 match_here;

    assign exp_q      = exp_reg;
    assign id_q       = id_reg;
    // entry sorts strictly after the key, so the key goes in front of it
    assign gt         = ctl.occupied && (exp_reg > key_exp);
    assign match_here = ctl.occupied && (id_reg == key_id) && !match_in;
    assign match_out  = match_in || match_here;

    always_comb begin
        exp_next = exp_reg;
        id_next  = id_reg;
        case (ctl.op)
            OP_INSERT: begin
                if (left_gt) begin
                    exp_next = left_exp;
                    id_next  = left_id;
                end else if (gt || !ctl.occupied) begin
                    exp_next = key_exp;
                    id_next  = key_id;
                end
            end
            OP_DELETE: begin
                if (match_out) begin
                    exp_next = right_exp;
                    id_next  = right_id;
                end
            end
            OP_POP: begin
                exp_next = right_exp;
                id_next  = right_id;
            end
            default: begin
                exp_next = exp_reg;
                id_next  = id_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        exp_reg <= exp_next;
        id_reg  <= id_next;
    end

endmodule

// ===== sv/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// pending timers kept sorted by expiry in a row of shifting cells
// ----------------------------------------------------------------------------
// Holds up to QUEUE_DEPTH timers as (id, expiry) pairs, sorted by unsigned
// expiry with equal expiries in arrival order. Each input transfer carries
// an action in s_axis_tuser: add absolute, add relative to current_time,
// delete the earliest entry with the given id, or tick. After the action,
// every head entry whose signed (expiry - current_time) is zero or negative
// is sent out as fired, one per cycle unless m_axis_tready is held low, and
// a final transfer (tlast high) reports the new head deadline or that the
// queue is empty. An add to a full queue gives a reject transfer followed by
// the head report. Inserts, deletes and pops are each done by all cells at
// once, with each cell taking data from itself, its left or its right
// neighbour. An item is accepted, applied, then its results are sent in
// turn; s_axis_tready is high only between items.
module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = stq_pkg::DEF_TIME_BITS,
    parameter int ID_BITS     = stq_pkg::DEF_ID_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    // input channel
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // timer_id, time_value, current_time (lowest bits first)
    input  logic [((ID_BITS+2*TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [1:0] s_axis_tuser,
    // result channel
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_timer_id, deadline (lowest bits first)
    output logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata,
    // kind
    output logic [1:0] m_axis_tuser,
    // marks the final result transfer of an item
    output logic m_axis_tlast
);
    import stq_pkg::*;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W  = ((ID_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - ID_BITS - TIME_BITS;

    // unpacked input fields
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_tv;
    logic [TIME_BITS-1:0] in_now;
    action_t              in_act;

    assign in_id  = s_axis_tdata[ID_BITS-1:0];
    assign in_tv  = s_axis_tdata[ID_BITS+TIME_BITS-1:ID_BITS];
    assign in_now = s_axis_tdata[ID_BITS+2*TIME_BITS-1:ID_BITS+TIME_BITS];
    assign in_act = action_t'(s_axis_tuser);

    // item held while it is worked on
    state_t               state_reg, state_next;
    action_t              act_reg;
    logic [ID_BITS-1:0]   key_id_reg;
    logic [TIME_BITS-1:0] key_exp_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    kind_t                m_kind_reg, m_kind_next;
    logic [ID_BITS-1:0]   m_id_reg, m_id_next;
    logic [TIME_BITS-1:0] m_dl_reg, m_dl_next;
    logic                 m_last_reg, m_last_next;

    // cell row
    cell_op_t             op;
    logic [TIME_BITS-1:0] cell_exp   [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   cell_id    [QUEUE_DEPTH];
    logic                 cell_gt    [QUEUE_DEPTH];
    logic                 cell_match [QUEUE_DEPTH];

    logic                 s_fire;
    logic                 slot_free;
    logic                 full;
    logic                 is_add;
    logic                 head_due;
    logic [TIME_BITS-1:0] head_diff;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    // the output register can take a new result this cycle
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign full          = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_add        = (act_reg == ACT_ADD_ABS) || (act_reg == ACT_ADD_REL);

    // signed test: due when the wrapped difference is zero or negative
    assign head_diff = cell_exp[0] - now_reg;
    assign head_due  = (count_reg != '0)
                       && ((head_diff == '0) || head_diff[TIME_BITS-1]);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [TIME_BITS-1:0] l_exp, r_exp;
            logic [ID_BITS-1:0]   l_id, r_id;
            logic                 l_gt, m_in;
            cell_ctl_t            ctl;

            if (gi == 0) begin : g_first
                assign l_exp = key_exp_reg;
                assign l_id  = key_id_reg;
                assign l_gt  = 1'b0;
                assign m_in  = 1'b0;
            end else begin : g_inner
                assign l_exp = cell_exp[gi-1];
                assign l_id  = cell_id[gi-1];
                assign l_gt  = cell_gt[gi-1];
                assign m_in  = cell_match[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_last
                // tail takes its own value back; it leaves the live range
                assign r_exp = cell_exp[gi];
                assign r_id  = cell_id[gi];
            end else begin : g_body
                assign r_exp = cell_exp[gi+1];
                assign r_id  = cell_id[gi+1];
            end

            assign ctl.op       = op;
            assign ctl.occupied = (count_reg > CNT_W'(gi));

            stq_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .key_exp   (key_exp_reg),
                .key_id    (key_id_reg),
                .left_exp  (l_exp),
                .left_id   (l_id),
                .left_gt   (l_gt),
                .right_exp (r_exp),
                .right_id  (r_id),
                .match_in  (m_in),
                .exp_q     (cell_exp[gi]),
                .id_q      (cell_id[gi]),
                .gt        (cell_gt[gi]),
                .match_out (cell_match[gi])
            );
        end
    endgenerate

    // item registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg    <= in_act;
            key_id_reg <= in_id;
            now_reg    <= in_now;
            // relative add wraps modulo the time width
            key_exp_reg <= (in_act == ACT_ADD_REL) ? (in_now + in_tv) : in_tv;
        end
    end

    // sequencer: next state, cell operation, count and result
    always_comb begin
        state_next   = state_reg;
        op           = OP_HOLD;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_dl_next    = m_dl_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (is_add && full) begin
                    // reject transfer, queue untouched, no firing pass
                    if (slot_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_REJECT;
                        m_id_next    = key_id_reg;
                        m_dl_next    = key_exp_reg;
                        m_last_next  = 1'b0;
                        state_next   = ST_REPORT;
                    end
                end else begin
                    if (is_add) begin
                        op         = OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end else if (act_reg == ACT_DELETE) begin
                        op = OP_DELETE;
                        if (cell_match[QUEUE_DEPTH-1]) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (head_due) begin
                        op          = OP_POP;
                        count_next  = count_reg - CNT_W'(1);
                        m_kind_next = KIND_FIRED;
                        m_id_next   = cell_id[0];
                        m_dl_next   = cell_exp[0];
                        m_last_next = 1'b0;
                    end else begin
                        m_kind_next = (count_reg == '0) ? KIND_EMPTY : KIND_HEAD;
                        m_id_next   = (count_reg == '0) ? '0 : cell_id[0];
                        m_dl_next   = (count_reg == '0) ? '0 : cell_exp[0];
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_REPORT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = (count_reg == '0) ? KIND_EMPTY : KIND_HEAD;
                    m_id_next    = (count_reg == '0) ? '0 : cell_id[0];
                    m_dl_next    = (count_reg == '0) ? '0 : cell_exp[0];
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_id_reg   <= m_id_next;
        m_dl_reg   <= m_dl_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    generate
        if (OUT_PAD > 0) begin : g_pad
            assign m_axis_tdata = {{OUT_PAD{1'b0}}, m_dl_reg, m_id_reg};
        end else begin : g_nopad
            assign m_axis_tdata = {m_dl_reg, m_id_reg};
        end
    endgenerate

endmodule

// ===== sim/stq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stq_checker
// watches both channels of the sorted timer queue and checks every result
// ----------------------------------------------------------------------------
// Keeps its own sorted copy of the pending timers. Every accepted input
// transfer is played into that copy, and the results it should cause are
// queued. Each accepted result transfer is then compared, field by field,
// with the oldest queued result. The failure count and the number of
// results still awaited go back to the testbench top.
module stq_checker #(
    parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = stq_pkg::DEF_TIME_BITS,
    parameter int ID_BITS     = stq_pkg::DEF_ID_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    input  logic s_axis_tready,
    // timer_id, time_value, current_time (lowest bits first)
    input  logic [((ID_BITS+2*TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [1:0] s_axis_tuser,
    input  logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_timer_id, deadline (lowest bits first) on m_axis_tdata after the counters
    output int   mismatches,
    output int   pending,
    input  logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata,
    // kind
    input  logic [1:0] m_axis_tuser,
    input  logic m_axis_tlast
);
    import stq_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct {
        kind_t                kind;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] deadline;
        logic                 last;
    } timer_result_t;

    // sorted copy of the pending timers
    logic [TIME_BITS-1:0] slot_expiry [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   slot_id     [QUEUE_DEPTH];
    int unsigned          slot_count;

    timer_result_t awaited_results [$];
    int unsigned   result_index;

    // signed distance to the deadline is zero or negative
    function automatic bit is_due(input logic [TIME_BITS-1:0] expiry,
                                  input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] diff;
        diff = expiry - now;
        return (diff == '0) || diff[TIME_BITS-1];
    endfunction

    function automatic void drop_slot(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < slot_count; i++) begin
            slot_expiry[i] = slot_expiry[i+1];
            slot_id[i]     = slot_id[i+1];
        end
        slot_count--;
    endfunction

    function automatic timer_result_t make_result(input kind_t kind,
                                                  input logic [ID_BITS-1:0] id,
                                                  input logic [TIME_BITS-1:0] dl);
        timer_result_t r;
        r.kind     = kind;
        r.id       = id;
        r.deadline = dl;
        r.last     = 1'b0;
        return r;
    endfunction

    task automatic model_timer_action(input action_t act,
                                      input logic [ID_BITS-1:0] id,
                                      input logic [TIME_BITS-1:0] tv,
                                      input logic [TIME_BITS-1:0] now);
        timer_result_t        batch [$];
        timer_result_t        r;
        logic [TIME_BITS-1:0] expiry;
        int unsigned          pos;
        int unsigned          i;
        int unsigned          k;
        bit                   rejected;
        bit                   found;
        rejected = 1'b0;
        found    = 1'b0;
        case (act)
            ACT_ADD_ABS, ACT_ADD_REL: begin
                expiry = (act == ACT_ADD_ABS) ? tv : now + tv;
                if (slot_count >= QUEUE_DEPTH) begin
                    batch.push_back(make_result(KIND_REJECT, id, expiry));
                    rejected = 1'b1;
                end else begin
                    // behind every entry with an equal expiry
                    pos = 0;
                    while (pos < slot_count && slot_expiry[pos] <= expiry)
                        pos++;
                    for (i = slot_count; i > pos; i--) begin
                        slot_expiry[i] = slot_expiry[i-1];
                        slot_id[i]     = slot_id[i-1];
                    end
                    slot_expiry[pos] = expiry;
                    slot_id[pos]     = id;
                    slot_count++;
                end
            end
            ACT_DELETE: begin
                for (i = 0; i < slot_count && !found; i++) begin
                    if (slot_id[i] == id) begin
                        drop_slot(i);
                        found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!rejected) begin
            while (slot_count > 0 && is_due(slot_expiry[0], now)) begin
                batch.push_back(make_result(KIND_FIRED, slot_id[0], slot_expiry[0]));
                drop_slot(0);
            end
        end
        if (slot_count == 0)
            batch.push_back(make_result(KIND_EMPTY, '0, '0));
        else
            batch.push_back(make_result(KIND_HEAD, slot_id[0], slot_expiry[0]));
        for (k = 0; k < batch.size(); k++) begin
            r      = batch[k];
            r.last = (k + 1 == batch.size());
            awaited_results.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("result %0d: %s is %0h, predicted %0h", result_index, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        timer_result_t want;
        if (awaited_results.size() == 0) begin
            flag_mismatch("unawaited transfer, kind", 64'(m_axis_tuser), 64'(0));
        end else begin
            want = awaited_results.pop_front();
            if (m_axis_tuser !== want.kind)
                flag_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
            if (m_axis_tdata[ID_BITS-1:0] !== want.id)
                flag_mismatch("timer id", 64'(m_axis_tdata[ID_BITS-1:0]), 64'(want.id));
            if (m_axis_tdata[ID_BITS +: TIME_BITS] !== want.deadline)
                flag_mismatch("deadline", 64'(m_axis_tdata[ID_BITS +: TIME_BITS]),
                              64'(want.deadline));
            if (m_axis_tlast !== want.last)
                flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        end
        result_index++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            slot_count   = 0;
            result_index = 0;
            mismatches   = 0;
            awaited_results.delete();
            pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                model_timer_action(action_t'(s_axis_tuser),
                                   s_axis_tdata[ID_BITS-1:0],
                                   s_axis_tdata[ID_BITS +: TIME_BITS],
                                   s_axis_tdata[ID_BITS+TIME_BITS +: TIME_BITS]);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            pending <= awaited_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the sorted timer queue
// ----------------------------------------------------------------------------
// Drives a short directed sequence (past and zero-distance deadlines, wrap of
// relative adds, equal expiries, duplicate ids, deletes of present and absent
// ids, a full queue with rejects and a tick that fires every entry), then
// random episodes: routine timer traffic on a slowly advancing clock, bursts
// that fill the queue and fire many entries with one tick, and raw noise. Both sides
// idle at random. The checker beside the block does all predicting.
module tb_top;
    import stq_pkg::*;

    localparam int ID_W         = DEF_ID_BITS;
    localparam int TIME_W       = DEF_TIME_BITS;
    localparam int S_W          = ((ID_W + 2*TIME_W + 7)/8)*8;
    localparam int M_W          = ((ID_W + TIME_W + 7)/8)*8;
    localparam int RANDOM_ITEMS = 340;
    localparam int PAUSE_EVERY  = 120;
    localparam int DRAIN_CYCLES = 40;
    // watchdog limit, set with a wide margin over the slowest run
    localparam int CYCLE_LIMIT  = 600000;

    logic           aclk          = 1'b0;
    logic           aresetn       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata  = '0;
    logic [1:0]     s_axis_tuser  = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;
    logic [1:0]     m_axis_tuser;
    logic           m_axis_tlast;

    int             mismatches;
    int             pending;

    int unsigned    cycle_count = 0;
    int unsigned    items_sent  = 0;
    int unsigned    random_start;
    int unsigned    next_pause;
    int unsigned    episode;
    int unsigned    i;
    int unsigned    rx_hold = 0;
    int unsigned    rx_draw;
    logic           rx_quiet = 1'b0;
    bit             tx_quiet = 1'b0;
    logic [TIME_W-1:0] now_t;
    logic [ID_W-1:0]   recent_ids [$];

    always #4 aclk = ~aclk;

    sorted_timer_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    stq_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .mismatches    (mismatches),
        .pending       (pending),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // result side: random stall before each result, none while quiet
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 12);
            rx_hold       <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_timer_queue verification failed");
            $finish;
        end
    end

    // one input transfer; tvalid only drops when a gap is drawn
    task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] tv, input logic [TIME_W-1:0] now);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_W'({now, tv, id});
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold the sender off until every awaited result has been taken
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // mostly a small id set so that deletes and duplicates hit
    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        if ($urandom_range(0, 99) < 85)
            id = ID_W'($urandom_range(0, 15));
        else
            id = ID_W'($urandom);
        recent_ids.push_back(id);
        if (recent_ids.size() > 24)
            void'(recent_ids.pop_front());
        return id;
    endfunction

    function automatic logic [ID_W-1:0] known_id();
        int unsigned     idx;
        logic [ID_W-1:0] id;
        if (recent_ids.size() == 0 || $urandom_range(0, 9) == 0)
            return ID_W'($urandom);
        idx = $urandom_range(0, recent_ids.size() - 1);
        id  = recent_ids[idx];
        recent_ids.delete(idx);
        return id;
    endfunction

    // ordinary traffic on a clock that creeps forward, with the odd big jump
    task automatic send_routine_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            now_t = now_t + TIME_W'($urandom);
        else
            now_t = now_t + TIME_W'($urandom_range(0, 20));
        if (pick < 35) begin
            send_item(ACT_ADD_REL, fresh_id(), TIME_W'($urandom_range(0, 60)), now_t);
        end else if (pick < 50) begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_ADD_ABS, fresh_id(), TIME_W'($urandom), now_t);
            else
                send_item(ACT_ADD_ABS, fresh_id(), now_t + TIME_W'($urandom_range(0, 80)),
                          now_t);
        end else if (pick < 70) begin
            send_item(ACT_DELETE, known_id(), TIME_W'($urandom), now_t);
        end else begin
            send_item(ACT_TICK, ID_W'($urandom), TIME_W'($urandom), now_t);
        end
    endtask

    // many far adds with coarse expiries (lots of ties), then one big tick
    task automatic send_fill_burst();
        int unsigned n;
        n = $urandom_range(12, 22);
        repeat (n) begin
            if ($urandom_range(0, 1))
                send_item(ACT_ADD_ABS, fresh_id(),
                          now_t + TIME_W'(100 * $urandom_range(1, 30)), now_t);
            else
                send_item(ACT_ADD_REL, fresh_id(), TIME_W'(100 * $urandom_range(1, 30)),
                          now_t);
            if ($urandom_range(0, 4) == 0)
                send_item(ACT_DELETE, known_id(), TIME_W'($urandom), now_t);
        end
        now_t = now_t + TIME_W'($urandom_range(1500, 4000));
        send_item(ACT_TICK, ID_W'($urandom), TIME_W'($urandom), now_t);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(2, 6))
            send_item(action_t'($urandom_range(0, 3)), ID_W'($urandom), TIME_W'($urandom),
                      TIME_W'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, deadline already past, relative wrap into the past
        send_item(ACT_TICK,    8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_ADD_ABS, 8'hff, 32'hffff_ffff, 32'h0000_0000);
        send_item(ACT_ADD_REL, 8'h00, 32'hffff_ffff, 32'h0000_0005);
        // zero distance fires
        send_item(ACT_ADD_ABS, 8'h5a, 32'd1000, 32'd1000);
        // largest positive distance stays pending
        send_item(ACT_ADD_REL, 8'ha5, 32'h7fff_ffff, 32'h8000_0000);
        // equal expiries keep arrival order, then a duplicate id ahead of them
        send_item(ACT_ADD_ABS, 8'h01, 32'd200, 32'd10);
        send_item(ACT_ADD_ABS, 8'h02, 32'd200, 32'd10);
        send_item(ACT_ADD_ABS, 8'h01, 32'd150, 32'd10);
        // delete takes the earliest of the duplicates; then an absent id
        send_item(ACT_DELETE,  8'h01, 32'd0, 32'd20);
        send_item(ACT_DELETE,  8'h77, 32'd0, 32'd20);
        // three entries held, thirteen more fill the queue with ties
        for (i = 0; i < 13; i++) begin
            if (i % 2 == 0)
                send_item(ACT_ADD_ABS, ID_W'(8'h10 + i), TIME_W'(300 + 100 * (i % 3)), 32'd20);
            else
                send_item(ACT_ADD_REL, ID_W'(8'h10 + i), TIME_W'(280 + 100 * (i % 3)), 32'd20);
        end
        // both kinds of add rejected while full
        send_item(ACT_ADD_ABS, 8'hfe, 32'h0000_0000, 32'd20);
        send_item(ACT_ADD_REL, 8'h3c, 32'hffff_ffff, 32'd20);
        // every entry fires at once
        send_item(ACT_TICK,    8'hc3, 32'h1234_5678, 32'h0002_0000);
        wait_for_results();

        // random episodes
        now_t        = TIME_W'($urandom);
        random_start = items_sent;
        next_pause   = PAUSE_EVERY;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            episode  = $urandom_range(0, 9);
            if (episode < 6 || episode == 9) begin
                repeat ($urandom_range(8, 20)) send_routine_item();
            end else if (episode < 8) begin
                send_fill_burst();
            end else begin
                send_noise();
            end
            if (items_sent - random_start >= next_pause) begin
                wait_for_results();
                next_pause += PAUSE_EVERY;
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("sorted_timer_queue verification clean");
        else
            $display("sorted_timer_queue verification failed");
        $finish;
    end

endmodule
